/* hdl/json_string_unescaper_macros.svh */
// Assertion macros used by the RTL. Each expects clk in scope; all but JSU_ASSERT_NEXT_ALWAYS also need rst_n.
`ifndef JSON_STRING_UNESCAPER_MACROS_SVH
`define JSON_STRING_UNESCAPER_MACROS_SVH

// Same-cycle implication, masked during reset.
`define JSU_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("jsu assertion failed");

// Next-cycle implication, masked during reset.
`define JSU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("jsu assertion failed");

// Next-cycle implication, also checked across reset.
`define JSU_ASSERT_NEXT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("jsu assertion failed");

`endif

/* hdl/jsu_pkg.sv */
package jsu_pkg;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_N = 8'h6E;
  localparam logic [7:0] CH_T = 8'h74;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_WS_LO = 8'h09;
  localparam logic [7:0] CH_WS_HI = 8'h0D;

  typedef enum logic [1:0] {
    MODE_WAIT = 2'd0,
    MODE_STR  = 2'd1,
    MODE_ESC  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    KIND_CHAR  = 2'd0,
    KIND_CLOSE = 2'd1,
    KIND_ERR   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE          = 3'd0,
    ERR_MISSING_QUOTE = 3'd1,
    ERR_UNTERMINATED  = 3'd2,
    ERR_RAW_CONTROL   = 3'd3,
    ERR_BAD_ESCAPE    = 3'd4
  } err_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] char_value;
    err_t       error_code;
  } res_t;

  // Decoder verdict for one byte or end-of-input event.
  typedef struct packed {
    logic  has_result;
    res_t  res;
    mode_t mode_nxt;
  } dec_t;

endpackage

/* hdl/jsu_if.sv */
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] byte_value;

  modport source (output valid, output action, output byte_value, input ready);
  modport sink (input valid, input action, input byte_value, output ready);
endinterface

interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] char_value;
  logic [2:0] error_code;

  modport source (output valid, output kind, output char_value, output error_code,
                  input ready);
  modport sink (input valid, input kind, input char_value, input error_code,
                output ready);
endinterface

/* hdl/json_string_unescaper.sv */
// Path: input register, then decoder, then output register holding the result.
// Throughput: one input transaction per cycle unless a result waits on the output;
//   no-result bytes (leading whitespace, opening quote, backslash) still use the register.
// The parse mode is updated as an item leaves the input register, so the next byte
//   sees it at once; this mode loop sets the rate.
// Reset (rst_n low, synchronous): both stages empty, parse mode back to waiting.
`include "json_string_unescaper_macros.svh"

module json_string_unescaper
  import jsu_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  jsu_in_if.sink    in_ch,
  jsu_out_if.source out_ch
);

  // Input register: holds one accepted transaction.
  logic       s1_valid_r;
  logic       s1_valid_nxt;
  logic       s1_action_r;
  logic [7:0] s1_byte_r;

  // Parse mode, advanced when the held item is retired.
  mode_t mode_r;
  mode_t mode_nxt;

  dec_t dec;
  logic out_free;
  logic s1_adv;
  logic in_fire;

  jsu_decoder u_dec (
    .mode       (mode_r),
    .action     (s1_action_r),
    .byte_value (s1_byte_r),
    .dec        (dec)
  );

  // An item with no result retires regardless of the output side.
  assign s1_adv = s1_valid_r && (out_free || !dec.has_result);

  jsu_out_stage u_out (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (s1_adv && dec.has_result),
    .res    (dec.res),
    .free   (out_free),
    .out_ch (out_ch)
  );

  assign in_ch.ready  = !s1_valid_r || s1_adv;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign s1_valid_nxt = in_fire || (s1_valid_r && !s1_adv);
  assign mode_nxt     = s1_adv ? dec.mode_nxt : mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      mode_r     <= MODE_WAIT;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      mode_r     <= mode_nxt;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_action_r <= in_ch.action;
      s1_byte_r   <= in_ch.byte_value;
    end
  end

  // Any error drops the parser back to waiting.
  `JSU_ASSERT_NEXT(a_err_to_wait, s1_adv && dec.has_result && (dec.res.kind == KIND_ERR), mode_r == MODE_WAIT)
  // An escape is always resolved by the next retired item.
  `JSU_ASSERT_NEXT(a_esc_resolves, s1_adv && (mode_r == MODE_ESC), mode_r != MODE_ESC)
  // Error results carry a code and no character.
  `JSU_ASSERT_IMPLY(a_err_fields, out_ch.valid && (out_ch.kind == KIND_ERR), (out_ch.error_code != ERR_NONE) && (out_ch.char_value == 8'h00))
  // Both stages come out of reset empty and waiting.
  `JSU_ASSERT_NEXT_ALWAYS(a_reset_empty, !rst_n, !s1_valid_r && !out_ch.valid && (mode_r == MODE_WAIT))

endmodule

/* hdl/jsu_decoder.sv */
module jsu_decoder
  import jsu_pkg::*;
(
  input  mode_t      mode,
  input  logic       action,
  input  logic [7:0] byte_value,
  output dec_t       dec
);

  function automatic dec_t fail(input err_t code);
    dec_t d;
    d.has_result     = 1'b1;
    d.res.kind       = KIND_ERR;
    d.res.char_value = 8'h00;
    d.res.error_code = code;
    d.mode_nxt       = MODE_WAIT;
    return d;
  endfunction

  function automatic dec_t emit_char(input logic [7:0] ch, input mode_t m);
    dec_t d;
    d.has_result     = 1'b1;
    d.res.kind       = KIND_CHAR;
    d.res.char_value = ch;
    d.res.error_code = ERR_NONE;
    d.mode_nxt       = m;
    return d;
  endfunction

  logic is_space;

  assign is_space = (byte_value == CH_SPACE) ||
                    ((byte_value >= CH_WS_LO) && (byte_value <= CH_WS_HI));

  always_comb begin
    dec                = '0;
    dec.res.kind       = KIND_CHAR;
    dec.res.error_code = ERR_NONE;
    dec.mode_nxt       = mode;
    case (mode)
      MODE_STR: begin
        if (action) begin
          dec = fail(ERR_UNTERMINATED);
        end else if ((byte_value == CH_LF) || (byte_value == CH_TAB)) begin
          dec = fail(ERR_RAW_CONTROL);
        end else if (byte_value == CH_QUOTE) begin
          dec.has_result = 1'b1;
          dec.res.kind   = KIND_CLOSE;
          dec.mode_nxt   = MODE_WAIT;
        end else if (byte_value == CH_BSLASH) begin
          dec.mode_nxt = MODE_ESC;
        end else begin
          dec = emit_char(byte_value, MODE_STR);
        end
      end
      MODE_ESC: begin
        if (action) begin
          dec = fail(ERR_BAD_ESCAPE);
        end else begin
          case (byte_value)
            CH_QUOTE:  dec = emit_char(CH_QUOTE, MODE_STR);
            CH_BSLASH: dec = emit_char(CH_BSLASH, MODE_STR);
            CH_SLASH:  dec = emit_char(CH_SLASH, MODE_STR);
            CH_N:      dec = emit_char(CH_LF, MODE_STR);
            CH_T:      dec = emit_char(CH_TAB, MODE_STR);
            default:   dec = fail(ERR_BAD_ESCAPE);
          endcase
        end
      end
      default: begin
        // waiting for an opening quote
        if (action) begin
          dec = fail(ERR_MISSING_QUOTE);
        end else if (is_space) begin
          dec.mode_nxt = MODE_WAIT;
        end else if (byte_value == CH_QUOTE) begin
          dec.mode_nxt = MODE_STR;
        end else begin
          dec = fail(ERR_MISSING_QUOTE);
        end
      end
    endcase
  end

endmodule

/* hdl/jsu_out_stage.sv */
module jsu_out_stage
  import jsu_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic load,
  input  res_t res,
  output logic free,
  jsu_out_if.source out_ch
);

  logic out_valid_r;
  logic out_valid_nxt;
  res_t out_res_r;

  // free when empty or the held result leaves this cycle
  assign free          = !out_valid_r || out_ch.ready;
  assign out_valid_nxt = load || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.kind       = out_res_r.kind;
  assign out_ch.char_value = out_res_r.char_value;
  assign out_ch.error_code = out_res_r.error_code;

endmodule
